// File: rtl/efbt_pkg.sv
// ----------------------------------------------------------------------------
// efbt_pkg
// Types and constants shared by the booking table modules.
// ----------------------------------------------------------------------------
package efbt_pkg;

	typedef enum logic [2:0] {
		CMD_INSERT   = 3'd0,
		CMD_COUNT    = 3'd1,
		CMD_EARLIEST = 3'd2,
		CMD_DEL_MIN  = 3'd3,
		CMD_DEL_PID  = 3'd4,
		CMD_CLEAR    = 3'd5
	} cmd_e;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_FULL  = 3'd1,
		ST_EMPTY = 3'd2,
		ST_BDATE = 3'd3,
		ST_BTIME = 3'd4
	} status_e;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_SHIFT,
		FSM_DONE
	} fsm_e;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [15:0] patient_id;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [13:0] year;
		logic [4:0]  hour;
		logic [5:0]  minute;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  match_count;
		logic [4:0]  held_count;
		logic [15:0] out_patient;
		logic [4:0]  out_day;
		logic [3:0]  out_month;
		logic [13:0] out_year;
		logic [4:0]  out_hour;
		logic [5:0]  out_minute;
	} rsp_t;

	typedef struct packed {
		logic [15:0] pid;
		logic [13:0] y;
		logic [3:0]  m;
		logic [4:0]  d;
		logic [4:0]  h;
		logic [5:0]  mi;
	} entry_t;

	// control into the cell row
	typedef struct packed {
		logic   rotate;   // every cell takes its right neighbor, head wraps to tail
		logic   load;     // tail cell takes new entry
		entry_t load_val;
	} row_ctl_t;

	// century = y / 100 by reciprocal multiply, exact for 14-bit years
	function automatic logic date_ok(logic [4:0] d, logic [3:0] m, logic [13:0] y);
		logic        leap;
		logic [4:0]  len;
		logic [26:0] prod;
		logic [7:0]  cent;
		logic [13:0] rem;
		prod = y * 13'd5243;
		cent = prod[26:19];
		rem  = y - cent * 14'd100;
		leap = (y[1:0] == 2'd0) && ((rem != 14'd0) || (cent[1:0] == 2'd0));
		unique case (m)
			4'd2:                      len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
			default:                   len = 5'd31;
		endcase
		return (y != 14'd0) && (m >= 4'd1) && (m <= 4'd12) && (d >= 5'd1) && (d <= len);
	endfunction

	function automatic logic [37:0] sort_key(entry_t e);
		return {e.y, e.m, e.d, e.h, e.mi};
	endfunction

endpackage

// File: rtl/efbt_cell.sv
// ----------------------------------------------------------------------------
// efbt_cell
// One storage slot of the rotating booking row.
// ----------------------------------------------------------------------------
module efbt_cell (
	input  logic            clk,
	input  logic            rotate,
	input  logic            load,
	input  efbt_pkg::entry_t nb,
	input  efbt_pkg::entry_t load_val,
	output efbt_pkg::entry_t val
);
	import efbt_pkg::*;

	entry_t val_q;

	always_ff @(posedge clk) begin
		if (load) begin
			val_q <= load_val;
		end else if (rotate) begin
			val_q <= nb;
		end
	end

	assign val = val_q;
endmodule

// File: rtl/efbt_row.sv
// ----------------------------------------------------------------------------
// efbt_row
// Chain of cells; rotation moves each entry one place toward the head.
// ----------------------------------------------------------------------------
module efbt_row #(
	parameter int CAPACITY = 16
) (
	input  logic              clk,
	input  efbt_pkg::row_ctl_t ctl,
	input  logic [$clog2(CAPACITY+1)-1:0] tail,
	output efbt_pkg::entry_t  head
);
	import efbt_pkg::*;

	localparam int TW = $clog2(CAPACITY+1);

	entry_t vals [CAPACITY];
	entry_t nbs  [CAPACITY];

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			// cell at tail-1 receives head so the live segment rotates
			if (g == CAPACITY-1) begin : g_last
				assign nbs[g] = vals[0];
			end else begin : g_mid
				assign nbs[g] = (TW'(g + 1) == tail) ? vals[0] : vals[g+1];
			end
			efbt_cell u_cell (
				.clk      (clk),
				.rotate   (ctl.rotate),
				.load     (ctl.load && (TW'(g) == tail)),
				.nb       (nbs[g]),
				.load_val (ctl.load_val),
				.val      (vals[g])
			);
		end
	endgenerate

	assign head = vals[0];
endmodule

// File: rtl/earliest_first_booking_table.sv
// ----------------------------------------------------------------------------
// earliest_first_booking_table
// Bounded table of bookings with earliest-first reporting.
// ----------------------------------------------------------------------------
// Bookings sit in a row of CAPACITY cells that rotates one place per cycle
// toward the head. Insert loads the new entry at the tail. Count, earliest
// and delete commands rotate the held entries once to scan, and delete
// earliest takes a second rotation that drops the winner while keeping
// order; delete patient drops matches during its single pass. One command is
// in flight at a time; a result held back by the receiver stalls the next
// command.
module earliest_first_booking_table #(
	parameter int CAPACITY = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  efbt_pkg::req_t  in_data,
	output logic            out_valid,
	input  logic            out_stall,
	output efbt_pkg::rsp_t  out_data,
	input  logic            cfg_we,
	input  logic [4:0]      cfg_wdata
);
	import efbt_pkg::*;

	localparam int TW = $clog2(CAPACITY+1);

	fsm_e     state_q, state_d;
	req_t     req_q;
	rsp_t     rsp_q, rsp_d;
	status_e  st_q, acc_status;
	logic     out_valid_q;
	logic [4:0]  lim_q;
	logic [TW-1:0] total_q, tail_q, left_q, pos_q, best_q, acc_total;
	logic [4:0]  match_q;
	entry_t   best_e_q;
	logic     pass2_q;
	entry_t   head;
	row_ctl_t ctl;
	row_ctl_t      ctl_row;
	logic [TW-1:0] tail_row;
	logic     accept, drop, in_date_ok;
	logic [TW-1:0] lim_eff;

	assign lim_eff = ({27'd0, lim_q} < CAPACITY) ? TW'(lim_q) : TW'(CAPACITY);
	assign in_stall = (state_q != FSM_IDLE) || (out_valid_q && out_stall);
	assign accept = in_valid && !in_stall;
	assign in_date_ok = date_ok(in_data.day, in_data.month, in_data.year);

	// in a compaction pass an entry is dropped by not writing it back
	always_comb begin
		drop = 1'b0;
		if (state_q == FSM_SCAN && req_q.cmd == CMD_DEL_PID)
			drop = (head.pid == req_q.patient_id);
		else if (state_q == FSM_SHIFT)
			drop = (pos_q == best_q);
	end

	// entries rotate through the head; kept ones return at the tail
	always_comb begin
		ctl = '0;
		if (state_q == FSM_SCAN || state_q == FSM_SHIFT) begin
			ctl.rotate = 1'b1;
		end
	end

	// Insert: load at total. Scan: rotate segment [0,total) fully; dropped
	// entries are overwritten by shrinking the segment as they leave the head.
	always_comb begin
		ctl_row = ctl;
		tail_row = tail_q;
		if (state_q == FSM_DONE && req_q.cmd == CMD_INSERT && st_q == ST_OK) begin
			ctl_row.load = 1'b1;
			ctl_row.load_val = '{pid: req_q.patient_id, y: req_q.year, m: req_q.month,
				d: req_q.day, h: req_q.hour, mi: req_q.minute};
			tail_row = total_q - TW'(1);
		end
	end

	efbt_row #(.CAPACITY(CAPACITY)) u_row (
		.clk  (clk),
		.ctl  (ctl_row),
		.tail (tail_row),
		.head (head)
	);

	// status and held count decided at accept
	always_comb begin
		acc_status = ST_OK;
		acc_total  = total_q;
		unique case (cmd_e'(in_data.cmd))
			CMD_INSERT: begin
				if (total_q >= lim_eff) acc_status = ST_FULL;
				else if (!in_date_ok) acc_status = ST_BDATE;
				else if (in_data.hour > 5'd23 || in_data.minute > 6'd59)
					acc_status = ST_BTIME;
				else acc_total = total_q + TW'(1);
			end
			CMD_COUNT: if (!in_date_ok) acc_status = ST_BDATE;
			CMD_EARLIEST, CMD_DEL_MIN: if (total_q == '0) acc_status = ST_EMPTY;
			CMD_CLEAR: begin
				if (total_q == '0) acc_status = ST_EMPTY;
				else acc_total = '0;
			end
			default: ;
		endcase
	end

	always_comb begin
		rsp_d = '0;
		rsp_d.status = st_q;
		rsp_d.held_count = 5'(total_q);
		if (req_q.cmd == CMD_COUNT || req_q.cmd == CMD_DEL_PID)
			rsp_d.match_count = match_q;
		if ((req_q.cmd == CMD_EARLIEST || req_q.cmd == CMD_DEL_MIN) && st_q == ST_OK) begin
			rsp_d.out_patient = best_e_q.pid;
			rsp_d.out_day     = best_e_q.d;
			rsp_d.out_month   = best_e_q.m;
			rsp_d.out_year    = best_e_q.y;
			rsp_d.out_hour    = best_e_q.h;
			rsp_d.out_minute  = best_e_q.mi;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FSM_IDLE:  if (accept) state_d = FSM_DONE;
			FSM_SCAN:  if (left_q == TW'(1))
					state_d = (req_q.cmd == CMD_DEL_MIN && !pass2_q) ? FSM_SHIFT : FSM_DONE;
			FSM_SHIFT: if (left_q == TW'(1)) state_d = FSM_DONE;
			FSM_DONE:  state_d = FSM_IDLE;
			default:   state_d = FSM_IDLE;
		endcase
		if (state_q == FSM_IDLE && accept && total_q != '0 &&
			(in_data.cmd == CMD_COUNT || in_data.cmd == CMD_EARLIEST ||
			 in_data.cmd == CMD_DEL_MIN || in_data.cmd == CMD_DEL_PID) &&
			!(in_data.cmd == CMD_COUNT && !in_date_ok))
			state_d = FSM_SCAN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= FSM_IDLE;
			total_q     <= '0;
			tail_q      <= '0;
			lim_q       <= 5'd16;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) lim_q <= cfg_wdata;
			if (state_q == FSM_DONE) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				FSM_IDLE: begin
					if (accept) begin
						req_q   <= in_data;
						left_q  <= total_q;
						pos_q   <= '0;
						match_q <= '0;
						best_q  <= '0;
						pass2_q <= 1'b0;
						st_q    <= acc_status;
						tail_q  <= total_q;
						total_q <= acc_total;
					end
				end
				FSM_SCAN: begin
					if (left_q == TW'(1)) begin
						left_q <= total_q;
						pos_q  <= '0;
					end else begin
						left_q <= left_q - TW'(1);
						pos_q  <= pos_q + TW'(1);
					end
					if (req_q.cmd == CMD_COUNT && head.d == req_q.day &&
						head.m == req_q.month && head.y == req_q.year) begin
						match_q <= match_q + 5'd1;
					end else if (drop) begin
						match_q <= match_q + 5'd1;
						tail_q  <= tail_q - TW'(1);
						total_q <= total_q - TW'(1);
					end
					if (pos_q == '0 || sort_key(head) < sort_key(best_e_q)) begin
						best_e_q <= head;
						best_q   <= pos_q;
					end
				end
				FSM_SHIFT: begin
					left_q <= left_q - TW'(1);
					pos_q  <= pos_q + TW'(1);
					if (drop) begin
						tail_q  <= tail_q - TW'(1);
						total_q <= total_q - TW'(1);
					end
				end
				FSM_DONE: begin
					rsp_q  <= rsp_d;
					tail_q <= total_q;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = rsp_q;

	a_busy_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != FSM_IDLE) |-> in_stall) else $error("accept while busy");
	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= TW'(CAPACITY)) else $error("held count overflow");
	a_out_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(out_data))
		else $error("result dropped");
endmodule
